@@ hw/rtl/tsr_pkg.sv @@
`timescale 1ns / 1ps
package tsr_pkg;
   localparam int TILE_HEIGHT_DEF = 64;
   localparam int X_BITS_DEF = 10;
   localparam int ROW_BITS = 6;
   localparam int COLOR_BITS = 8;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_SORT  = 7'b0000010,
      ST_SETUP = 7'b0000100,
      ST_MUL   = 7'b0001000,
      ST_DIV   = 7'b0010000,
      ST_EMIT  = 7'b0100000,
      ST_NEXT  = 7'b1000000
   } ctl_state_type;

   // controller to datapath
   typedef struct packed {
      logic load;      // capture inputs
      logic sort;      // sort vertices, compute deltas
      logic setup;     // pick first row / half
      logic mul;       // form the two products
      logic div_start; // start both dividers
      logic emit;      // drive one result
      logic advance;   // step row / change half
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic flat;      // all rows equal
      logic div_done;
      logic done;      // no more rows after advance
   } dp_sts_type;
endpackage

@@ hw/rtl/tsr_divider.sv @@
`timescale 1ns / 1ps
// Restoring signed division, one quotient bit per cycle, truncation toward zero.
module tsr_divider import tsr_pkg::*; #(
   parameter int N_BITS = 24,
   parameter int D_BITS = 7
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [N_BITS-1:0] numer,
   input  logic        [D_BITS-1:0] denom,   // positive
   output logic signed [N_BITS-1:0] quot,
   output logic                     done
);
   localparam int CW = $clog2(N_BITS + 1);
   logic [N_BITS-1:0] q_ff, q_in;
   logic [D_BITS:0]   r_ff, r_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              neg_ff, neg_in, busy_ff, busy_in, done_ff, done_in;
   logic [D_BITS:0]   trial;
   logic [D_BITS:0]   shifted;

   always_comb begin
      q_in = q_ff; r_in = r_ff; cnt_in = cnt_ff; neg_in = neg_ff;
      busy_in = busy_ff; done_in = 1'b0;
      shifted = {r_ff[D_BITS-1:0], q_ff[N_BITS-1]};
      trial = shifted - {1'b0, denom};
      if (start) begin
         neg_in = numer[N_BITS-1];
         q_in = numer[N_BITS-1] ? N_BITS'(-numer) : numer;
         r_in = '0;
         cnt_in = CW'(N_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[D_BITS]) begin
            r_in = trial;
            q_in = {q_ff[N_BITS-2:0], 1'b1};
         end else begin
            r_in = shifted;
            q_in = {q_ff[N_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; cnt_ff <= cnt_in; neg_ff <= neg_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign quot = neg_ff ? -$signed(q_ff) : $signed(q_ff);
   assign done = done_ff;
endmodule

@@ hw/rtl/tsr_datapath.sv @@
`timescale 1ns / 1ps
module tsr_datapath import tsr_pkg::*; #(
   parameter int TILE_HEIGHT = TILE_HEIGHT_DEF,
   parameter int X_BITS = X_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   output dp_sts_type            sts,
   input  logic [X_BITS-1:0]     in_ax, in_bx, in_cx,
   input  logic [ROW_BITS-1:0]   in_ay, in_by, in_cy,
   input  logic [COLOR_BITS-1:0] in_color,
   output logic [ROW_BITS-1:0]   span_row,
   output logic [X_BITS-1:0]     span_left,
   output logic [X_BITS-1:0]     span_right,
   output logic                  draw,
   output logic [COLOR_BITS-1:0] span_color,
   output logic                  last
);
   localparam int DXW = X_BITS + 1;
   localparam int PW = DXW + ROW_BITS + 1;
   localparam logic [ROW_BITS-1:0] YMAX = ROW_BITS'(TILE_HEIGHT - 1);

   logic [X_BITS-1:0]     x_ff [3];
   logic [ROW_BITS-1:0]   y_ff [3];
   logic [COLOR_BITS-1:0] col_ff;
   logic signed [DXW-1:0] dxt_ff, dxl_ff, dxb_ff;
   logic [ROW_BITS-1:0]   dyt_ff, dyl_ff, dyb_ff;
   logic [ROW_BITS-1:0]   row_ff;
   logic                  lower_ff;
   logic signed [PW-1:0]  pa_ff, pb_ff;
   logic signed [PW-1:0]  qa, qb;
   logic                  da, db;
   logic [ROW_BITS-1:0]   c0, c1, c2;
   logic [X_BITS-1:0]     s0x, s1x, s2x;
   logic [ROW_BITS-1:0]   s0y, s1y, s2y;
   logic signed [DXW:0]   l, r;
   logic [ROW_BITS-1:0]   end_row;
   logic                  last_row;
   logic [ROW_BITS-1:0]   doff;
   logic signed [PW-1:0]  off0, off1, dxt_w, dxl_w, dxb_w;

   function automatic logic [ROW_BITS-1:0] clampy(input logic [ROW_BITS-1:0] v);
      return (v > YMAX) ? YMAX : v;
   endfunction

   assign c0 = clampy(in_ay);
   assign c1 = clampy(in_by);
   assign c2 = clampy(in_cy);

   // stable three-element sort network on captured vertices
   always_comb begin
      logic [X_BITS-1:0] tx;
      logic [ROW_BITS-1:0] ty;
      tx = '0; ty = '0;
      s0x = x_ff[0]; s0y = y_ff[0]; s1x = x_ff[1]; s1y = y_ff[1];
      s2x = x_ff[2]; s2y = y_ff[2];
      if (s0y > s1y) begin
         tx = s0x; ty = s0y; s0x = s1x; s0y = s1y; s1x = tx; s1y = ty;
      end
      if (s1y > s2y) begin
         tx = s1x; ty = s1y; s1x = s2x; s1y = s2y; s2x = tx; s2y = ty;
      end
      if (s0y > s1y) begin
         tx = s0x; ty = s0y; s0x = s1x; s0y = s1y; s1x = tx; s1y = ty;
      end
   end

   // full-width operands so the products cannot overflow
   assign off0  = $signed({{(PW-ROW_BITS){1'b0}}, row_ff - y_ff[0]});
   assign off1  = $signed({{(PW-ROW_BITS){1'b0}}, row_ff - y_ff[1]});
   assign dxt_w = $signed({{(PW-DXW){dxt_ff[DXW-1]}}, dxt_ff});
   assign dxl_w = $signed({{(PW-DXW){dxl_ff[DXW-1]}}, dxl_ff});
   assign dxb_w = $signed({{(PW-DXW){dxb_ff[DXW-1]}}, dxb_ff});

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff[0] <= in_ax; x_ff[1] <= in_bx; x_ff[2] <= in_cx;
         y_ff[0] <= c0; y_ff[1] <= c1; y_ff[2] <= c2;
         col_ff <= in_color;
      end
      if (cmd.sort) begin
         x_ff[0] <= s0x; x_ff[1] <= s1x; x_ff[2] <= s2x;
         y_ff[0] <= s0y; y_ff[1] <= s1y; y_ff[2] <= s2y;
         dxt_ff <= $signed({1'b0, s1x}) - $signed({1'b0, s0x});
         dxl_ff <= $signed({1'b0, s2x}) - $signed({1'b0, s0x});
         dxb_ff <= $signed({1'b0, s2x}) - $signed({1'b0, s1x});
         dyt_ff <= s1y - s0y;
         dyl_ff <= s2y - s0y;
         dyb_ff <= s2y - s1y;
      end
      if (cmd.setup) begin
         lower_ff <= (dyt_ff == '0);
         row_ff <= (dyt_ff == '0) ? y_ff[1] : y_ff[0];
      end
      if (cmd.mul) begin
         if (lower_ff) begin
            pa_ff <= off0 * dxl_w;
            pb_ff <= off1 * dxb_w;
         end else begin
            pa_ff <= off0 * dxt_w;
            pb_ff <= off0 * dxl_w;
         end
      end
      if (cmd.advance) begin
         if (!lower_ff && row_ff + 1'b1 == y_ff[1]) begin
            lower_ff <= 1'b1;
            row_ff <= y_ff[1];
         end else begin
            row_ff <= row_ff + 1'b1;
         end
      end
   end

   assign doff = lower_ff ? dyb_ff : dyt_ff;

   tsr_divider #(.N_BITS(PW), .D_BITS(ROW_BITS)) u_div_a (
      .clock, .reset, .start(cmd.div_start), .numer(pa_ff),
      .denom(lower_ff ? dyl_ff : dyt_ff), .quot(qa), .done(da));
   tsr_divider #(.N_BITS(PW), .D_BITS(ROW_BITS)) u_div_b (
      .clock, .reset, .start(cmd.div_start), .numer(pb_ff),
      .denom(lower_ff ? doff : dyl_ff), .quot(qb), .done(db));

   // lower half: a is long edge from v0, b is bottom edge from v1
   assign l = $signed({2'b0, x_ff[0]}) + (DXW+1)'(qa);
   assign r = $signed({2'b0, lower_ff ? x_ff[1] : x_ff[0]}) + (DXW+1)'(qb);

   assign end_row = lower_ff ? y_ff[2] : y_ff[1] - 1'b1;
   assign last_row = (row_ff == end_row) && (lower_ff || dyb_ff == '0);

   assign sts.flat = (y_ff[0] == y_ff[2]);
   assign sts.div_done = da & db;
   assign sts.done = last_row;

   always_comb begin
      if (sts.flat) begin
         span_row = y_ff[0]; span_left = '0; span_right = '0; draw = 1'b0;
         last = 1'b1;
      end else begin
         span_row = row_ff;
         span_left = (l < r) ? X_BITS'(l) : X_BITS'(r);
         span_right = (l < r) ? X_BITS'(r) : X_BITS'(l);
         draw = (l != r);
         last = last_row;
      end
   end
   assign span_color = col_ff;
endmodule

@@ hw/rtl/tsr_controller.sv @@
`timescale 1ns / 1ps
module tsr_controller import tsr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   output logic       strobe,
   output dp_cmd_type cmd,
   input  dp_sts_type sts
);
   ctl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: if (start) begin
            cmd.load = 1'b1; state_in = ST_SORT;
         end
         ST_SORT: begin
            cmd.sort = 1'b1; state_in = ST_SETUP;
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in = sts.flat ? ST_EMIT : ST_MUL;
         end
         ST_MUL: begin
            cmd.mul = 1'b1; state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_start = 1'b1; state_in = ST_NEXT;
         end
         ST_NEXT: if (sts.div_done) state_in = ST_EMIT;
         ST_EMIT: begin
            cmd.emit = 1'b1;
            if (sts.flat || sts.done) state_in = ST_IDLE;
            else begin
               cmd.advance = 1'b1; state_in = ST_MUL;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign strobe = (state_ff == ST_EMIT);

`ifndef NO_ASSERTIONS
   a_emit_from_wait: assert property (@(posedge clock) disable iff (reset)
      strobe |-> $past(state_ff == ST_NEXT) || $past(state_ff == ST_SETUP))
      else $error("emit without computation");
   a_idle_after_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && start) |=> state_ff == ST_SORT)
      else $error("load not followed by sort");
   a_mul_div: assert property (@(posedge clock) disable iff (reset)
      cmd.mul |=> cmd.div_start)
      else $error("divide not started after multiply");
`endif
endmodule

@@ hw/rtl/triangle_span_rasterizer_unit.sv @@
`timescale 1ns / 1ps
// Channel | Direction | Handshake          | Payload
// req_    | in        | start & !busy      | three vertices, fill color
// rsp_    | out       | rsp_strobe, 1 cyc  | row, left, right, draw, color, last
//
// After sort and setup, each scanline forms two products, runs the two parallel serial
// dividers (PW = X_BITS+8 bits wide) and emits one result once both are done.
// Flat triangles skip the multiply and divide and give their one result after setup.
// Reset: synchronous, active high; clears the controller and the divider flags.
// Stalls: none; the receiver takes every strobed result.
module triangle_span_rasterizer_unit import tsr_pkg::*; #(
   parameter int TILE_HEIGHT = TILE_HEIGHT_DEF,
   parameter int X_BITS = X_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [X_BITS-1:0]     req_vertex_a_x,
   input  logic [ROW_BITS-1:0]   req_vertex_a_y,
   input  logic [X_BITS-1:0]     req_vertex_b_x,
   input  logic [ROW_BITS-1:0]   req_vertex_b_y,
   input  logic [X_BITS-1:0]     req_vertex_c_x,
   input  logic [ROW_BITS-1:0]   req_vertex_c_y,
   input  logic [COLOR_BITS-1:0] req_fill_color,
   output logic                  rsp_strobe,
   output logic [ROW_BITS-1:0]   rsp_span_row,
   output logic [X_BITS-1:0]     rsp_span_left,
   output logic [X_BITS-1:0]     rsp_span_right,
   output logic                  rsp_draw,
   output logic [COLOR_BITS-1:0] rsp_span_color,
   output logic                  rsp_last
);
   dp_cmd_type cmd;
   dp_sts_type sts;

   // sequence one triangle at a time
   tsr_controller u_ctl (
      .clock, .reset, .start, .busy, .strobe(rsp_strobe), .cmd, .sts);

   // sort, interpolate and form spans
   tsr_datapath #(.TILE_HEIGHT(TILE_HEIGHT), .X_BITS(X_BITS)) u_dp (
      .clock, .reset, .cmd, .sts,
      .in_ax(req_vertex_a_x), .in_bx(req_vertex_b_x), .in_cx(req_vertex_c_x),
      .in_ay(req_vertex_a_y), .in_by(req_vertex_b_y), .in_cy(req_vertex_c_y),
      .in_color(req_fill_color),
      .span_row(rsp_span_row), .span_left(rsp_span_left),
      .span_right(rsp_span_right), .draw(rsp_draw),
      .span_color(rsp_span_color), .last(rsp_last));
endmodule
